// ----- src/glfp_pkg.sv -----
`default_nettype none
package glfp_pkg;

  // sizing
  localparam int MAX_ITEMS  = 32;
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int WEIGHT_W   = 16;
  localparam int VOL_W      = 24;
  localparam int CMD_W      = 2;
  localparam int ITEM_IDX_W = 6;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // sequencer to store
  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic                clr_all;
    logic                take_en;
    logic [IDX_W-1:0]    take_addr;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                scan_init;
  } glfp_ctrl_t;

  // store to sequencer
  typedef struct packed {
    logic                rd_vld;
    logic                best_valid;
    logic [IDX_W-1:0]    best_idx;
    logic [WEIGHT_W-1:0] best_w;
  } glfp_stat_t;

endpackage
`default_nettype wire

// ----- src/glfp_store.sv -----
`default_nettype none
module glfp_store import glfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire glfp_ctrl_t ctrl,
  input  wire logic [VOL_W-1:0] rem,
  output glfp_stat_t      stat
);

  logic [WEIGHT_W-1:0] mem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] taken;
  logic [WEIGHT_W-1:0] rd_data;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic                best_valid;
  logic [IDX_W-1:0]    best_idx;
  logic [WEIGHT_W-1:0] best_w;
  logic                fits;
  logic                better;

  // weight memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_addr];
    end
    rd_idx <= ctrl.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctrl.rd_en;
    end
  end

  // taken marks
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (ctrl.clr_all) begin
      taken <= '0;
    end else begin
      if (ctrl.wr_en) begin
        taken[ctrl.wr_addr] <= 1'b0;
      end
      if (ctrl.take_en) begin
        taken[ctrl.take_addr] <= 1'b1;
      end
    end
  end

  // shared compare unit: fits the volume and beats the best so far
  always_comb begin
    fits   = rd_vld && !taken[rd_idx] && (VOL_W'(rd_data) <= rem);
    better = fits && (!best_valid || (rd_data > best_w));
  end

  // running best, strict greater keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (ctrl.scan_init) begin
      best_valid <= 1'b0;
    end else if (better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx <= rd_idx;
      best_w   <= rd_data;
    end
  end

  assign stat.rd_vld     = rd_vld;
  assign stat.best_valid = best_valid;
  assign stat.best_idx   = best_idx;
  assign stat.best_w     = best_w;

endmodule
`default_nettype wire

// ----- src/greedy_largest_fit_packer.sv -----
// channel | signals                              | role
// in      | in_valid, in_ready                   | cmd, item_weight, container_volume
// out     | out_valid, out_ready                 | item_index, empty_res, last
//
// load and clear are done in the idle state; a fill repeats a serial scan over
// the n stored items for each pick, through the single read port of the weight
// memory, one weight per cycle.
// rst is synchronous and clears item count, taken marks and the sequencer.
// results leave through an output register; the scan waits only when a result
// is ready to go and that register is still held by the consumer.
`default_nettype none
module greedy_largest_fit_packer import glfp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [WEIGHT_W-1:0]   item_weight,
  input  wire logic [VOL_W-1:0]      container_volume,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ITEM_IDX_W-1:0]      item_index,
  output logic                       empty_res,
  output logic                       last
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      item_count, item_count_next;
  logic [VOL_W-1:0]      rem, rem_next;
  logic [CNT_W-1:0]      scan_addr, scan_addr_next;
  logic                  have_pend, have_pend_next;
  logic [ITEM_IDX_W-1:0] pend_idx, pend_idx_next;
  logic                  out_valid_next;
  logic [ITEM_IDX_W-1:0] item_index_next;
  logic                  empty_res_next, last_next;
  logic                  out_free;
  glfp_ctrl_t            ctrl;
  glfp_stat_t            stat;

  glfp_store u_store (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .rem  (rem),
    .stat (stat)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_count <= '0;
      rem        <= '0;
      have_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      item_count <= item_count_next;
      rem        <= rem_next;
      have_pend  <= have_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    pend_idx   <= pend_idx_next;
    item_index <= item_index_next;
    empty_res  <= empty_res_next;
    last       <= last_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    item_count_next = item_count;
    rem_next        = rem;
    scan_addr_next  = scan_addr;
    have_pend_next  = have_pend;
    pend_idx_next   = pend_idx;
    out_valid_next  = out_valid && !out_ready;
    item_index_next = item_index;
    empty_res_next  = empty_res;
    last_next       = last;
    out_free        = !out_valid || out_ready;
    ctrl            = '0;
    ctrl.wr_data    = item_weight;
    in_ready        = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_LOAD: begin
              if (item_count < CNT_W'(MAX_ITEMS)) begin
                ctrl.wr_en      = 1'b1;
                ctrl.wr_addr    = item_count[IDX_W-1:0];
                item_count_next = item_count + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              ctrl.clr_all    = 1'b1;
              item_count_next = '0;
            end
            CMD_FILL: begin
              rem_next       = container_volume;
              have_pend_next = 1'b0;
              state_next     = ST_START;
            end
            default: ;
          endcase
        end
      end

      // new pick round: reset the best and the scan address
      ST_START: begin
        ctrl.scan_init = 1'b1;
        scan_addr_next = '0;
        state_next     = (rem == '0) ? ST_DECIDE : ST_SCAN;
      end

      // one read per cycle, compared in the cycle after the read
      ST_SCAN: begin
        if (scan_addr < item_count) begin
          ctrl.rd_en     = 1'b1;
          ctrl.rd_addr   = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + CNT_W'(1);
        end else if (!stat.rd_vld) begin
          state_next = ST_DECIDE;
        end
      end

      // take the pick, or close out the fill; the held result learns its last flag here
      ST_DECIDE: begin
        if (stat.best_valid) begin
          if (!have_pend || out_free) begin
            if (have_pend) begin
              out_valid_next  = 1'b1;
              item_index_next = pend_idx;
              empty_res_next  = 1'b0;
              last_next       = 1'b0;
            end
            ctrl.take_en   = 1'b1;
            ctrl.take_addr = stat.best_idx;
            rem_next       = rem - VOL_W'(stat.best_w);
            pend_idx_next  = ITEM_IDX_W'(stat.best_idx) + ITEM_IDX_W'(1);
            have_pend_next = 1'b1;
            state_next     = ST_START;
          end
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          item_index_next = have_pend ? pend_idx : '0;
          empty_res_next  = !have_pend;
          last_next       = 1'b1;
          have_pend_next  = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // a pick never exceeds what is left of the container
  a_pick_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && stat.best_valid |-> (VOL_W'(stat.best_w) <= rem))
    else $error("picked weight exceeds remaining volume");

  // store fill never passes its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store depth");

  // an accepted fill keeps the input closed in the next cycle
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_FILL) |=> !in_ready)
    else $error("input open right after a fill transfer");

  // the empty result is always the final one and carries index zero
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (item_index == '0))
    else $error("malformed empty result");

  // no pick is pending while idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !have_pend)
    else $error("held result left behind after fill");

endmodule
`default_nettype wire

// ----- sim/glfp_checker.sv -----
`default_nettype none
module glfp_checker import glfp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [WEIGHT_W-1:0]   item_weight,
  input  wire logic [VOL_W-1:0]      container_volume,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [ITEM_IDX_W-1:0] item_index,
  input  wire logic                  empty_res,
  input  wire logic                  last,
  output int                         errors,
  output int                         outstanding,
  output int                         picks_seen
);

  localparam int NO_FIT = -1;

  typedef struct packed {
    logic [ITEM_IDX_W-1:0] idx;
    logic                  empty;
    logic                  last;
  } pick_t;

  // expected results of fills, oldest first
  pick_t               expected_picks[$];
  logic [WEIGHT_W-1:0] weights [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] taken;
  int                  n_items;
  int                  mismatch_count;
  int                  pick_count;

  // greedy largest-fit over the untaken items, lowest slot wins a tie
  task automatic predict_fill(input logic [VOL_W-1:0] volume);
    logic [VOL_W-1:0] room;
    int               best;
    int               picked;
    pick_t            p;
    room   = volume;
    picked = 0;
    while (room != '0 && picked < MAX_ITEMS) begin
      best = NO_FIT;
      for (int k = 0; k < n_items; k++) begin
        if (!taken[k] && weights[k] <= room &&
            (best == NO_FIT || weights[k] > weights[best])) begin
          best = k;
        end
      end
      if (best == NO_FIT) break;
      taken[best] = 1'b1;
      room        = room - VOL_W'(weights[best]);
      p.idx       = ITEM_IDX_W'(best + 1);
      p.empty     = 1'b0;
      p.last      = 1'b0;
      expected_picks.push_back(p);
      picked++;
    end
    // a fill that packs nothing still reports once
    if (picked == 0) begin
      p.idx   = '0;
      p.empty = 1'b1;
      p.last  = 1'b1;
      expected_picks.push_back(p);
    end else begin
      p      = expected_picks.pop_back();
      p.last = 1'b1;
      expected_picks.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      taken   = '0;
      n_items = 0;
      expected_picks.delete();
    end else begin
      // compare result transfer against oldest expectation
      if (out_valid && out_ready) begin
        pick_count++;
        if (expected_picks.size() == 0) begin
          mismatch_count++;
          $error("unexpected result: item_index %0d empty_res %0b last %0b",
                 item_index, empty_res, last);
        end else begin
          want = expected_picks.pop_front();
          if (item_index !== want.idx) begin
            mismatch_count++;
            $error("item_index: expected %0d, got %0d", want.idx, item_index);
          end
          if (empty_res !== want.empty) begin
            mismatch_count++;
            $error("empty_res: expected %0b, got %0b", want.empty, empty_res);
          end
          if (last !== want.last) begin
            mismatch_count++;
            $error("last: expected %0b, got %0b", want.last, last);
          end
        end
      end
      // command transfer updates the model
      if (in_valid && in_ready) begin
        case (cmd)
          CMD_LOAD: begin
            if (n_items < MAX_ITEMS) begin
              weights[n_items] = item_weight;
              taken[n_items]   = 1'b0;
              n_items++;
            end
          end
          CMD_FILL: predict_fill(container_volume);
          CMD_CLEAR: begin
            taken   = '0;
            n_items = 0;
          end
          default: ;
        endcase
      end
    end
    errors      <= mismatch_count;
    outstanding <= expected_picks.size();
    picks_seen  <= pick_count;
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
module tb;
  import glfp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               PHASE_ITEMS = 55;

  logic                  clk              = 1'b0;
  logic                  rst              = 1'b1;
  logic                  in_valid         = 1'b0;
  logic [CMD_W-1:0]      cmd              = CMD_LOAD;
  logic [WEIGHT_W-1:0]   item_weight      = '0;
  logic [VOL_W-1:0]      container_volume = '0;
  logic                  out_ready        = 1'b0;
  wire logic             in_ready;
  wire logic             out_valid;
  wire logic [ITEM_IDX_W-1:0] item_index;
  wire logic             empty_res;
  wire logic             last;

  int errors;
  int outstanding;
  int picks_seen;

  // stimulus knobs and bookkeeping
  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic rx_hold     = 1'b0;
  int stored        = 0;
  int stored_sum    = 0;
  int useful        = 0;
  int n_loads       = 0;
  int n_fills       = 0;
  int n_clears      = 0;
  int n_unused      = 0;

  always #10 clk = ~clk;

  greedy_largest_fit_packer u_top (
    .clk, .rst, .in_valid, .in_ready, .cmd, .item_weight, .container_volume,
    .out_valid, .out_ready, .item_index, .empty_res, .last
  );

  glfp_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .cmd, .item_weight, .container_volume,
    .out_valid, .out_ready, .item_index, .empty_res, .last,
    .errors, .outstanding, .picks_seen
  );

  // consumer side: random stalls plus a forced hold-off
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one command and wait for its transfer
  task automatic send(input logic [CMD_W-1:0] c, input logic [WEIGHT_W-1:0] w,
                      input logic [VOL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    cmd              <= c;
    item_weight      <= w;
    container_volume <= v;
    @(posedge clk iff in_ready);
    case (c)
      CMD_LOAD: begin
        n_loads++;
        if (stored < MAX_ITEMS) begin
          stored++;
          stored_sum += int'(w);
          useful++;
        end
      end
      CMD_FILL: begin
        n_fills++;
        useful++;
      end
      CMD_CLEAR: begin
        n_clears++;
        stored     = 0;
        stored_sum = 0;
        useful++;
      end
      default: n_unused++;
    endcase
  endtask

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 45) return WEIGHT_W'($urandom_range(1, 300));
    if (r < 49) return '0;
    if (r < 54) return '1;
    return WEIGHT_W'($urandom);
  endfunction

  // volumes mostly around what the store holds, so fills stop for both reasons
  function automatic logic [VOL_W-1:0] rand_volume();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 60) return VOL_W'($urandom_range(stored_sum));
    if (r < 80) return VOL_W'(stored_sum + $urandom_range(50));
    if (r < 92) return VOL_W'($urandom);
    return '1;
  endfunction

  // usually clear, then load a set, then a few fills; sometimes overfill or add noise
  task automatic run_batch();
    int n;
    int fills;
    if ($urandom_range(99) < 85) send(CMD_CLEAR, rand_weight(), VOL_W'($urandom));
    n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 34);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) send(CMD_UNUSED, rand_weight(), VOL_W'($urandom));
      send(CMD_LOAD, rand_weight(), VOL_W'($urandom));
    end
    fills = $urandom_range(1, 4);
    for (int i = 0; i < fills; i++) send(CMD_FILL, rand_weight(), rand_volume());
  endtask

  task automatic run_phase(input int idle_pct, input int stall);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    target        = useful + PHASE_ITEMS;
    while (useful < target) run_batch();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, unused code, extreme weights, ties, zero weight
    send(CMD_FILL, 16'h1234, 24'hFFFFFF);
    send(CMD_UNUSED, 16'hFFFF, 24'hFFFFFF);
    send(CMD_LOAD, 16'hFFFF, 24'h000000);
    send(CMD_LOAD, 16'h0001, 24'h000000);
    send(CMD_LOAD, 16'h0000, 24'h000000);
    send(CMD_LOAD, 16'h8000, 24'h000000);
    send(CMD_LOAD, 16'h8000, 24'h000000);
    send(CMD_LOAD, 16'h7FFF, 24'h000000);
    send(CMD_FILL, 16'h0000, 24'h000000);
    send(CMD_FILL, 16'h0000, 24'h008000);
    send(CMD_FILL, 16'h0000, 24'h010000);
    send(CMD_FILL, 16'h0000, 24'hFFFFFF);
    send(CMD_FILL, 16'h0000, 24'h000005);
    send(CMD_CLEAR, 16'h0000, 24'h000000);
    send(CMD_FILL, 16'h0000, 24'h000001);
    send(CMD_LOAD, 16'h0002, 24'h000000);
    send(CMD_LOAD, 16'h0003, 24'h000000);
    send(CMD_FILL, 16'h0000, 24'h000004);

    // random traffic under each idling pattern
    run_phase(0, 0);
    run_phase(82, 0);
    run_phase(0, 82);
    run_phase(37, 37);

    // full store, long consumer hold-off: output backs up and stalls the input
    send_idle_pct = 0;
    stall_pct     = 20;
    send(CMD_CLEAR, 16'h0000, 24'h000000);
    for (int i = 0; i < MAX_ITEMS; i++) send(CMD_LOAD, WEIGHT_W'($urandom_range(1, 100)), '0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        send(CMD_FILL, 16'h0000, 24'hFFFFFF);
        send(CMD_FILL, 16'h0000, 24'h0003E8);
        send(CMD_LOAD, 16'h0005, 24'h000000);
        send(CMD_CLEAR, 16'h0000, 24'h000000);
      end
    join

    // drain
    in_valid <= 1'b0;
    @(posedge clk iff (outstanding == 0));
    repeat (1200) @(posedge clk);

    $display("covered %0d loads, %0d fills, %0d clears, %0d unused codes",
             n_loads, n_fills, n_clears, n_unused);
    $display("checked %0d results across four idling patterns and a hold-off",
             picks_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/glfp_pkg.sv
src/glfp_store.sv
src/greedy_largest_fit_packer.sv
sim/glfp_checker.sv
sim/tb.sv
